// File: sv/keypad_password_lock_controller_defines.svh
// Assertion macros for the keypad password lock controller.
// Used by keypad_password_lock_controller.sv; expects clk and arst_n in scope.
`ifndef KEYPAD_PASSWORD_LOCK_CONTROLLER_DEFINES_SVH
`define KEYPAD_PASSWORD_LOCK_CONTROLLER_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define KPL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define KPL_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// File: sv/kplc_pkg.sv
// Types and constants shared by the keypad password lock controller.
// No dependencies.
package kplc_pkg;

	typedef enum logic [2:0] {
		MODE_NEW     = 3'd0,
		MODE_CONFIRM = 3'd1,
		MODE_MENU    = 3'd2,
		MODE_OLD     = 3'd3,
		MODE_ALARM   = 3'd4,
		MODE_DOOR    = 3'd5
	} mode_t;

	typedef enum logic [3:0] {
		EV_NONE       = 4'd0,
		EV_STORED     = 4'd1,
		EV_MISMATCH   = 4'd2,
		EV_WRONG      = 4'd3,
		EV_ALARM_ON   = 4'd4,
		EV_ALARM_OFF  = 4'd5,
		EV_DOOR_START = 4'd6,
		EV_DOOR_DONE  = 4'd7,
		EV_CHANGE     = 4'd8
	} event_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_OPEN  = 2'd1,
		PH_HOLD  = 2'd2,
		PH_CLOSE = 2'd3
	} phase_t;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_TRIES   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALARM_TICKS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OPEN_END    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_END    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CLOSE_END   = 3'd4;

	localparam logic [2:0] MAX_TRIES_RST   = 3'd3;
	localparam logic [7:0] ALARM_TICKS_RST = 8'd120;
	localparam logic [7:0] OPEN_END_RST    = 8'd30;
	localparam logic [7:0] HOLD_END_RST    = 8'd36;
	localparam logic [7:0] CLOSE_END_RST   = 8'd66;

	localparam logic       CMD_KEY  = 1'b0;
	localparam logic       CMD_TICK = 1'b1;
	localparam logic [7:0] KEY_CHANGE = 8'h2A;
	localparam logic [7:0] KEY_DOOR   = 8'h25;
	localparam logic [7:0] TICK_MAX   = 8'hFF;
	localparam logic [2:0] TRIES_MAX  = 3'd7;

	typedef struct packed {
		logic       cmd;
		logic [7:0] key_code;
	} in_t;

	typedef struct packed {
		mode_t      mode;
		event_t     event_res;
		phase_t     door_phase;
		logic [2:0] wrong_count;
		logic [2:0] key_position;
		logic       key_taken;
	} out_t;

endpackage

// File: sv/keypad_password_lock_controller.sv
// Keypad password lock controller: password entry, confirm, menu, lockout and door sequence.
// Depends on kplc_pkg and keypad_password_lock_controller_defines.svh.
// Stage one registers an accepted word with its memory read; the output register then
// takes its result word. One word per cycle while out_ready holds; the password memory is
// read at acceptance, its address forwarded from the next state of the word in flight.
// Reset: mode, counters, bank select, valids clear, cfg loads defaults; memory not cleared.
`include "keypad_password_lock_controller_defines.svh"

module keypad_password_lock_controller #(
	parameter int unsigned PASSWORD_LENGTH = 6,
	parameter int unsigned KEY_WIDTH = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  kplc_pkg::in_t                    in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output kplc_pkg::out_t                   out_data,
	input  logic                             cfg_we,
	input  logic [kplc_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [kplc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int unsigned IDX_W = (PASSWORD_LENGTH > 1) ? $clog2(PASSWORD_LENGTH) : 1;
	localparam int unsigned PW = $clog2(PASSWORD_LENGTH + 1);
	localparam int unsigned ADDR_W = IDX_W + 1;
	localparam int unsigned MEM_DEPTH = 2 ** ADDR_W;
	localparam logic [7:0] KEY_MASK = 8'((9'd1 << KEY_WIDTH) - 9'd1);
	localparam logic [PW-1:0] POS_LAST = PW'(PASSWORD_LENGTH - 1);
	localparam logic [PW-1:0] POS_END = PW'(PASSWORD_LENGTH);

	// two banks: sel_q marks the stored password, the other bank takes new entry
	logic [KEY_WIDTH-1:0] mem [MEM_DEPTH];

	logic [2:0] max_tries_q;
	logic [7:0] alarm_ticks_q, open_end_q, hold_end_q, close_end_q;

	kplc_pkg::mode_t mode_q, mode_d, mode_eff;
	logic [PW-1:0]   pos_q, pos_d, pos_eff, pos_inc, shown;
	logic            mis_q, mis_d, mis_now;
	logic [2:0]      wt_q, wt_d, wt_sat;
	logic [7:0]      tick_q, tick_d, tick_inc;
	logic            chg_q, chg_d;
	logic            sel_q, sel_d, sel_eff;

	logic                 v_s1;
	kplc_pkg::in_t        in_s1;
	logic [KEY_WIDTH-1:0] rd_s1;

	logic              out_valid_q;
	kplc_pkg::out_t    out_q, out_d;
	kplc_pkg::event_t  ev;
	kplc_pkg::phase_t  phase;
	logic              taken;
	logic [PW+2:0]     shown_ext;

	logic [7:0]           key8;
	logic [KEY_WIDTH-1:0] key;
	logic                 last, bad_key;
	logic                 adv, accept, wr_en;
	logic [ADDR_W-1:0]    rd_addr, wr_addr;

	assign adv = !out_valid_q || out_ready;
	assign in_ready = !v_s1 || adv;
	assign accept = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	assign key8 = in_s1.key_code & KEY_MASK;
	assign key = key8[KEY_WIDTH-1:0];
	assign pos_inc = pos_q + 1'b1;
	assign last = (pos_q == POS_LAST);
	assign bad_key = (rd_s1 != key);
	assign wt_sat = (wt_q != kplc_pkg::TRIES_MAX) ? wt_q + 3'd1 : wt_q;
	assign tick_inc = (tick_q != kplc_pkg::TICK_MAX) ? tick_q + 8'd1 : tick_q;

	// forward the next state of the word in flight to the read address
	assign mode_eff = v_s1 ? mode_d : mode_q;
	assign pos_eff = v_s1 ? pos_d : pos_q;
	assign sel_eff = v_s1 ? sel_d : sel_q;
	assign rd_addr = {(mode_eff == kplc_pkg::MODE_CONFIRM) ? ~sel_eff : sel_eff,
		pos_eff[IDX_W-1:0]};
	assign wr_addr = {~sel_q, pos_q[IDX_W-1:0]};
	assign wr_en = v_s1 && adv && (in_s1.cmd == kplc_pkg::CMD_KEY) &&
		(mode_q == kplc_pkg::MODE_NEW);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= key;
		end
		if (accept) begin
			rd_s1 <= (wr_en && (wr_addr == rd_addr)) ? key : mem[rd_addr];
			in_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_tries_q <= kplc_pkg::MAX_TRIES_RST;
			alarm_ticks_q <= kplc_pkg::ALARM_TICKS_RST;
			open_end_q <= kplc_pkg::OPEN_END_RST;
			hold_end_q <= kplc_pkg::HOLD_END_RST;
			close_end_q <= kplc_pkg::CLOSE_END_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				kplc_pkg::REG_MAX_TRIES:   max_tries_q <= cfg_wdata[2:0];
				kplc_pkg::REG_ALARM_TICKS: alarm_ticks_q <= cfg_wdata;
				kplc_pkg::REG_OPEN_END:    open_end_q <= cfg_wdata;
				kplc_pkg::REG_HOLD_END:    hold_end_q <= cfg_wdata;
				kplc_pkg::REG_CLOSE_END:   close_end_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		mode_d = mode_q;
		pos_d = pos_q;
		mis_d = mis_q;
		wt_d = wt_q;
		tick_d = tick_q;
		chg_d = chg_q;
		sel_d = sel_q;
		ev = kplc_pkg::EV_NONE;
		taken = 1'b0;
		shown = pos_q;
		mis_now = mis_q | ((mode_q != kplc_pkg::MODE_NEW) && bad_key);
		if (in_s1.cmd == kplc_pkg::CMD_KEY) begin
			unique case (mode_q)
				kplc_pkg::MODE_NEW, kplc_pkg::MODE_CONFIRM, kplc_pkg::MODE_OLD: begin
					taken = 1'b1;
					shown = pos_inc;
					if (last) begin
						pos_d = '0;
						mis_d = 1'b0;
						if (mode_q == kplc_pkg::MODE_NEW) begin
							mode_d = kplc_pkg::MODE_CONFIRM;
						end else if (mode_q == kplc_pkg::MODE_CONFIRM) begin
							if (mis_now) begin
								ev = kplc_pkg::EV_MISMATCH;
								mode_d = kplc_pkg::MODE_NEW;
							end else begin
								ev = kplc_pkg::EV_STORED;
								mode_d = kplc_pkg::MODE_MENU;
								sel_d = ~sel_q;
							end
						end else if (mis_now) begin
							wt_d = wt_sat;
							if (wt_sat >= max_tries_q) begin
								ev = kplc_pkg::EV_ALARM_ON;
								mode_d = kplc_pkg::MODE_ALARM;
								tick_d = '0;
							end else begin
								ev = kplc_pkg::EV_WRONG;
							end
						end else begin
							wt_d = '0;
							tick_d = '0;
							if (chg_q) begin
								ev = kplc_pkg::EV_CHANGE;
								mode_d = kplc_pkg::MODE_NEW;
							end else begin
								ev = kplc_pkg::EV_DOOR_START;
								mode_d = kplc_pkg::MODE_DOOR;
							end
						end
					end else begin
						pos_d = pos_inc;
						mis_d = mis_now;
					end
				end
				kplc_pkg::MODE_MENU: begin
					if ((key8 == kplc_pkg::KEY_CHANGE) || (key8 == kplc_pkg::KEY_DOOR)) begin
						chg_d = (key8 == kplc_pkg::KEY_CHANGE);
						mode_d = kplc_pkg::MODE_OLD;
						pos_d = '0;
						mis_d = 1'b0;
						wt_d = '0;
						shown = '0;
					end
				end
				default: ;
			endcase
		end else begin
			unique case (mode_q)
				kplc_pkg::MODE_ALARM: begin
					tick_d = tick_inc;
					if (tick_inc >= alarm_ticks_q) begin
						ev = kplc_pkg::EV_ALARM_OFF;
						mode_d = kplc_pkg::MODE_MENU;
						tick_d = '0;
						wt_d = '0;
					end
				end
				kplc_pkg::MODE_DOOR: begin
					tick_d = tick_inc;
					if (tick_inc >= close_end_q) begin
						ev = kplc_pkg::EV_DOOR_DONE;
						mode_d = kplc_pkg::MODE_MENU;
						tick_d = '0;
					end
				end
				default: ;
			endcase
		end
	end

	// result word
	always_comb begin
		if (mode_d != kplc_pkg::MODE_DOOR) begin
			phase = kplc_pkg::PH_IDLE;
		end else if (tick_d < open_end_q) begin
			phase = kplc_pkg::PH_OPEN;
		end else if (tick_d < hold_end_q) begin
			phase = kplc_pkg::PH_HOLD;
		end else begin
			phase = kplc_pkg::PH_CLOSE;
		end
		shown_ext = {3'b000, shown};
		out_d.mode = mode_d;
		out_d.event_res = ev;
		out_d.door_phase = phase;
		out_d.wrong_count = wt_d;
		out_d.key_position = shown_ext[2:0];
		out_d.key_taken = taken;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= kplc_pkg::MODE_NEW;
			pos_q <= '0;
			mis_q <= 1'b0;
			wt_q <= '0;
			tick_q <= '0;
			chg_q <= 1'b0;
			sel_q <= 1'b0;
		end else if (v_s1 && adv) begin
			mode_q <= mode_d;
			pos_q <= pos_d;
			mis_q <= mis_d;
			wt_q <= wt_d;
			tick_q <= tick_d;
			chg_q <= chg_d;
			sel_q <= sel_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (v_s1 && adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && adv) begin
			out_q <= out_d;
		end
	end

	`KPL_NEVER(a_pos_range, pos_q >= POS_END, "entry position out of range")
	`KPL_NEVER(a_phase_idle,
		out_valid_q && (out_q.mode != kplc_pkg::MODE_DOOR) &&
		(out_q.door_phase != kplc_pkg::PH_IDLE), "door phase outside door mode")
	`KPL_ASSERT(a_bank_flip, (sel_q != $past(sel_q)) |->
		(out_valid_q && (out_q.event_res == kplc_pkg::EV_STORED)),
		"bank select moved without a stored password")
	`KPL_ASSERT(a_s1_hold, (v_s1 && !adv) |=> v_s1, "stalled word dropped from stage one")

endmodule
